// ===== hdl/wrfm_pkg.sv =====
// Shared types, codes and constants for the wildcard rule first-match table
`timescale 1ns / 1ps

package wrfm_pkg;

    // default table depth
    localparam int MAX_RULES_DEF = 64;

    // field widths
    localparam int ID_W     = 16;
    localparam int ACT_W    = 2;
    localparam int HIT_W    = 6;
    localparam int STATUS_W = 2;

    // stored rule layout
    localparam int ENTRY_W    = 53;
    localparam int SVC_LSB    = 16;
    localparam int MTH_LSB    = 32;
    localparam int WILD_C_BIT = 48;
    localparam int WILD_S_BIT = 49;
    localparam int WILD_M_BIT = 50;
    localparam int ACT_LSB    = 51;

    // stream widths
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;

    // request kinds
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_CHECK = 1'b1;

    // action codes
    localparam logic [ACT_W-1:0] ACT_ACCEPT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DENY   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOG    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_BAD    = 2'd3;

    // add status codes
    localparam logic [STATUS_W-1:0] ST_NONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // one request as unpacked from the input stream
    typedef struct packed {
        logic            mode;
        logic [ID_W-1:0] cli_id;
        logic            client_wild;
        logic [ID_W-1:0] svc_id;
        logic            service_wild;
        logic [ID_W-1:0] mth_id;
        logic            method_wild;
        logic [ACT_W-1:0] rule_action;
    } req_t;

    // one result
    typedef struct packed {
        logic [ACT_W-1:0]    verdict;
        logic                hit;
        logic [HIT_W-1:0]    hit_index;
        logic [STATUS_W-1:0] add_status;
    } res_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic match;
        logic scan_end;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/wrfm_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module wrfm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/wrfm_dp.sv =====
// Datapath: request registers, rule table scan, match logic and result register
`timescale 1ns / 1ps

module wrfm_dp
    import wrfm_pkg::*;
#(
    parameter int MAX_RULES = MAX_RULES_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    input  req_t    req,
    input  logic    out_ready,
    output status_t st,
    output logic    out_valid,
    output res_t    res
);

    localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CW = $clog2(MAX_RULES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_RULES);

    logic                mode_reg;
    logic [ENTRY_W-1:0]  entry_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       scan_idx_reg;
    logic                pend_valid_reg;
    logic [CW-1:0]       pend_idx_reg;
    logic                hit_reg;
    logic [CW-1:0]       hit_idx_reg;
    logic [ACT_W-1:0]    hit_act_reg;
    logic                out_valid_reg;
    res_t                out_res_reg;

    logic [ENTRY_W-1:0]  entry_next;
    logic [ACT_W-1:0]    act_norm;
    logic [ENTRY_W-1:0]  rule;
    logic                more;
    logic                issue;
    logic                fm_c;
    logic                fm_s;
    logic                fm_m;
    logic                cmp;
    logic                match;
    logic                full;
    logic                ram_we;
    res_t                res_next;

    // rule table
    wrfm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_RULES),
        .ADDR_W(AW)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[AW-1:0]),
        .wdata(entry_reg),
        .raddr(scan_idx_reg[AW-1:0]),
        .rdata(rule)
    );

    // normalize an add request: wildcard ids to zero, unknown action to deny
    always_comb
    begin
        act_norm = (req.rule_action == ACT_BAD) ? ACT_DENY : req.rule_action;
        entry_next = '0;
        if (req.mode == MODE_ADD)
        begin
            entry_next[ID_W-1:0]           = req.client_wild  ? '0 : req.cli_id;
            entry_next[SVC_LSB +: ID_W]    = req.service_wild ? '0 : req.svc_id;
            entry_next[MTH_LSB +: ID_W]    = req.method_wild  ? '0 : req.mth_id;
            entry_next[WILD_C_BIT]         = req.client_wild;
            entry_next[WILD_S_BIT]         = req.service_wild;
            entry_next[WILD_M_BIT]         = req.method_wild;
            entry_next[ACT_LSB +: ACT_W]   = act_norm;
        end
        else
        begin
            entry_next[ID_W-1:0]        = req.cli_id;
            entry_next[SVC_LSB +: ID_W] = req.svc_id;
            entry_next[MTH_LSB +: ID_W] = req.mth_id;
        end
    end

    // compare the rule returned by the table
    always_comb
    begin
        fm_c  = rule[WILD_C_BIT] | (rule[ID_W-1:0] == entry_reg[ID_W-1:0]);
        fm_s  = rule[WILD_S_BIT] | (rule[SVC_LSB +: ID_W] == entry_reg[SVC_LSB +: ID_W]);
        fm_m  = rule[WILD_M_BIT] | (rule[MTH_LSB +: ID_W] == entry_reg[MTH_LSB +: ID_W]);
        cmp   = (mode_reg == MODE_ADD) ? (rule == entry_reg) : (fm_c & fm_s & fm_m);
        match = pend_valid_reg & cmp;
        more  = scan_idx_reg < count_reg;
        issue = cmd.scan & ~match & more;
        full  = count_reg >= FULL_COUNT;
    end

    // status to the controller
    always_comb
    begin
        st.match    = match;
        st.scan_end = ~pend_valid_reg & ~more;
        st.out_free = ~out_valid_reg | out_ready;
    end

    // result of the finished request
    always_comb
    begin
        res_next = '0;
        ram_we   = 1'b0;
        if (mode_reg == MODE_CHECK)
        begin
            if (hit_reg)
            begin
                res_next.verdict   = hit_act_reg;
                res_next.hit       = 1'b1;
                res_next.hit_index = HIT_W'(hit_idx_reg);
            end
            else
            begin
                res_next.verdict = ACT_DENY;
            end
        end
        else if (hit_reg)
        begin
            res_next.add_status = ST_DUP;
        end
        else if (full)
        begin
            res_next.add_status = ST_FULL;
        end
        else
        begin
            res_next.add_status = ST_ADDED;
            ram_we              = cmd.finish;
        end
    end

    // request registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= req.mode;
            entry_reg <= entry_next;
        end
    end

    // scan control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= issue;
            if (issue)
            begin
                pend_idx_reg <= scan_idx_reg;
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
                hit_reg      <= 1'b0;
            end
            else if (match)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    // first hit position and action
    always_ff @(posedge clk)
    begin
        if (match)
        begin
            hit_idx_reg <= pend_idx_reg;
            hit_act_reg <= rule[ACT_LSB +: ACT_W];
        end
    end

    // rule count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ram_we)
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = out_res_reg;

    // checks
    a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> count_reg < FULL_COUNT)
        else $error("rule table written while full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("rule count beyond table depth");

    a_read_stored: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> pend_idx_reg < count_reg)
        else $error("compare on an entry that was never stored");

    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished request did not reach the output register");

endmodule

// ===== hdl/wrfm_ctrl.sv =====
// Controller: request sequencing through accept, table scan and result hand-off
`timescale 1ns / 1ps

module wrfm_ctrl
    import wrfm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  status_t st,
    output logic    in_ready,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.match || st.scan_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/wildcard_rule_first_match_top.sv =====
// Top level of the wildcard rule first-match table: stream ports, controller and datapath
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata rule or message ids, s_tuser kind
//  m_*      out  m_tvalid/m_tready  m_tdata verdict, hit, index, add status
//
//  A scan reads one rule per cycle from the single table read port; a request
//  goes from accept through the table scan and the finish state to the result,
//  and the controller then returns to idle to accept the next request.
//  A check stops at its first matching rule, an add at its first duplicate.
//  Reset clears the rule count; table contents need no clearing pass.
//  A new request is accepted while a result waits in the output register; it
//  then holds after its scan until that result is taken.
`timescale 1ns / 1ps

module wildcard_rule_first_match_top
    import wrfm_pkg::*;
#(
    parameter int MAX_RULES = MAX_RULES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // client id[15:0] client_wild[16] service id[32:17] service_wild[33]
    // method id[49:34] method_wild[50] rule_action[52:51], zero pad above
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // mode[0]
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // verdict[1:0] hit[2] hit_index[8:3] add_status[10:9], zero pad above
    output logic [OUT_DATA_W-1:0] m_tdata
);

    req_t    req;
    res_t    res;
    cmd_t    cmd;
    status_t st;

    // unpack the request
    always_comb
    begin
        req.mode         = s_tuser[0];
        req.cli_id       = s_tdata[15:0];
        req.client_wild  = s_tdata[16];
        req.svc_id       = s_tdata[32:17];
        req.service_wild = s_tdata[33];
        req.mth_id       = s_tdata[49:34];
        req.method_wild  = s_tdata[50];
        req.rule_action  = s_tdata[52:51];
    end

    wrfm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_tvalid),
        .st      (st),
        .in_ready(s_tready),
        .cmd     (cmd)
    );

    wrfm_dp #(
        .MAX_RULES(MAX_RULES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req),
        .out_ready(m_tready),
        .st       (st),
        .out_valid(m_tvalid),
        .res      (res)
    );

    // pack the result
    assign m_tdata = {5'd0, res.add_status, res.hit_index, res.hit, res.verdict};

endmodule

// ===== dv/tb.sv =====
// Testbench for the wildcard rule first-match table: directed and random requests
`timescale 1ns / 1ps

module tb;
    import wrfm_pkg::*;

    localparam int TABLE_DEPTH  = MAX_RULES_DEF;
    localparam int CLK_PERIOD   = 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
    localparam int MAX_PRINTS   = 40;

    // one stored rule, identifiers of wildcard fields already zeroed
    typedef struct packed {
        logic [ID_W-1:0]  cli_id;
        logic [ID_W-1:0]  svc_id;
        logic [ID_W-1:0]  mth_id;
        logic             client_wild;
        logic             service_wild;
        logic             method_wild;
        logic [ACT_W-1:0] action;
    } acl_rule_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [0:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // predictor state
    acl_rule_t acl_rules [TABLE_DEPTH];
    int        acl_count = 0;
    res_t      pending_verdicts [$];

    // traffic shaping
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // bookkeeping
    int err_count     = 0;
    int cycle_count   = 0;
    int request_count = 0;
    int n_added       = 0;
    int n_dup         = 0;
    int n_full        = 0;
    int n_hit         = 0;
    int n_default     = 0;
    int deepest_hit   = -1;

    logic [ID_W-1:0] id_pool [4] = '{16'h0001, 16'h8000, 16'h00FF, 16'h5A5A};

    wildcard_rule_first_match_top #(
        .MAX_RULES (TABLE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_verdicts.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
    endtask

    // result checker
    always @(posedge clk)
    begin : result_check
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.verdict    = m_tdata[1:0];
            got.hit        = m_tdata[2];
            got.hit_index  = m_tdata[8:3];
            got.add_status = m_tdata[10:9];
            if (pending_verdicts.size() == 0)
                report_mismatch("unrequested result", m_tdata, '0);
            else
            begin
                want = pending_verdicts.pop_front();
                if (got.verdict !== want.verdict)
                    report_mismatch("verdict", 16'(got.verdict), 16'(want.verdict));
                if (got.hit !== want.hit)
                    report_mismatch("hit", 16'(got.hit), 16'(want.hit));
                if (got.hit_index !== want.hit_index)
                    report_mismatch("hit_index", 16'(got.hit_index), 16'(want.hit_index));
                if (got.add_status !== want.add_status)
                    report_mismatch("add_status", 16'(got.add_status),
                                    16'(want.add_status));
            end
        end
    end

    // expected result of one request, updating the rule table
    function automatic res_t classify_request(input req_t r);
        res_t      res;
        acl_rule_t rule;
        bit        dup;
        res = '0;
        dup = 1'b0;
        request_count++;
        if (r.mode == MODE_ADD)
        begin
            rule.client_wild  = r.client_wild;
            rule.service_wild = r.service_wild;
            rule.method_wild  = r.method_wild;
            rule.cli_id       = r.client_wild ? '0 : r.cli_id;
            rule.svc_id       = r.service_wild ? '0 : r.svc_id;
            rule.mth_id       = r.method_wild ? '0 : r.mth_id;
            rule.action       = (r.rule_action == ACT_BAD) ? ACT_DENY : r.rule_action;
            for (int i = 0; i < acl_count; i++)
                if (acl_rules[i] == rule)
                    dup = 1'b1;
            if (dup)
            begin
                res.add_status = ST_DUP;
                n_dup++;
            end
            else if (acl_count >= TABLE_DEPTH)
            begin
                res.add_status = ST_FULL;
                n_full++;
            end
            else
            begin
                acl_rules[acl_count] = rule;
                acl_count++;
                res.add_status = ST_ADDED;
                n_added++;
            end
            return res;
        end
        // check: first matching rule in insertion order
        res.verdict = ACT_DENY;
        for (int i = 0; i < acl_count; i++)
        begin
            if ((acl_rules[i].client_wild || acl_rules[i].cli_id == r.cli_id) &&
                (acl_rules[i].service_wild || acl_rules[i].svc_id == r.svc_id) &&
                (acl_rules[i].method_wild || acl_rules[i].mth_id == r.mth_id))
            begin
                res.verdict   = acl_rules[i].action;
                res.hit       = 1'b1;
                res.hit_index = i[HIT_W-1:0];
                n_hit++;
                if (i > deepest_hit)
                    deepest_hit = i;
                return res;
            end
        end
        n_default++;
        return res;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_request(input req_t r);
        logic [IN_DATA_W-1:0] d;
        d        = '0;
        d[15:0]  = r.cli_id;
        d[16]    = r.client_wild;
        d[32:17] = r.svc_id;
        d[33]    = r.service_wild;
        d[49:34] = r.mth_id;
        d[50]    = r.method_wild;
        d[52:51] = r.rule_action;
        return d;
    endfunction

    function automatic req_t make_request(input logic mode, input logic [15:0] cid,
                                          input logic cw, input logic [15:0] sid,
                                          input logic sw, input logic [15:0] mid,
                                          input logic mw, input logic [1:0] act);
        req_t r;
        r.mode         = mode;
        r.cli_id       = cid;
        r.client_wild  = cw;
        r.svc_id       = sid;
        r.service_wild = sw;
        r.mth_id       = mid;
        r.method_wild  = mw;
        r.rule_action  = act;
        return r;
    endfunction

    // identifiers biased toward extremes and a small shared pool
    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2, 3: return id_pool[$urandom_range(3)];
            default: return ID_W'($urandom);
        endcase
    endfunction

    function automatic req_t random_request(input int add_pct);
        req_t      r;
        acl_rule_t src;
        r.mode = ($urandom_range(99) < add_pct) ? MODE_ADD : MODE_CHECK;
        // last slot is kept for the catch-all rule
        if (acl_count == TABLE_DEPTH - 1)
            r.mode = MODE_CHECK;
        r.cli_id       = pick_id();
        r.svc_id       = pick_id();
        r.mth_id       = pick_id();
        r.client_wild  = ($urandom_range(99) < 15);
        r.service_wild = ($urandom_range(99) < 15);
        r.method_wild  = ($urandom_range(99) < 15);
        r.rule_action  = ACT_W'($urandom_range(3));
        // no catch-all before the table is full, it would shadow everything behind it
        if (r.mode == MODE_ADD && acl_count < TABLE_DEPTH &&
            r.client_wild && r.service_wild && r.method_wild)
            r.method_wild = 1'b0;
        // aim half of the checks at a stored rule
        if (r.mode == MODE_CHECK && acl_count > 0 && $urandom_range(1))
        begin
            src = acl_rules[$urandom_range(acl_count - 1)];
            if (!src.client_wild)
                r.cli_id = src.cli_id;
            if (!src.service_wild)
                r.svc_id = src.svc_id;
            if (!src.method_wild)
                r.mth_id = src.mth_id;
        end
        return r;
    endfunction

    // send one request; entered and left just after a falling edge
    task automatic send_request(input req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_request(r);
        s_tuser  <= r.mode;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_verdicts.insert(pending_verdicts.size(), classify_request(r));
        @(negedge clk);
    endtask

    // hold off the sender until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_default_deny();
        // empty table, ignored fields all set
        send_request(make_request(MODE_CHECK, '1, 1'b1, '1, 1'b1, '1, 1'b1, ACT_BAD));
        send_request(make_request(MODE_CHECK, '0, 1'b0, '0, 1'b0, '0, 1'b0, ACT_ACCEPT));
    endtask

    task automatic test_exact_and_duplicate();
        send_request(make_request(MODE_ADD, '0, 1'b0, '0, 1'b0, '0, 1'b0, ACT_ACCEPT));
        send_request(make_request(MODE_ADD, '0, 1'b0, '0, 1'b0, '0, 1'b0, ACT_ACCEPT));
        send_request(make_request(MODE_ADD, '1, 1'b0, '1, 1'b0, '1, 1'b0, ACT_LOG));
        send_request(make_request(MODE_CHECK, '0, 1'b0, '0, 1'b0, '0, 1'b0, ACT_LOG));
        send_request(make_request(MODE_CHECK, '1, 1'b0, '1, 1'b0, '1, 1'b0, ACT_ACCEPT));
    endtask

    task automatic test_wildcard_rules();
        // unknown action stored as deny
        send_request(make_request(MODE_ADD, 16'h1234, 1'b1, 16'h0005, 1'b0, 16'h0006, 1'b0,
                                  ACT_BAD));
        // same rule apart from the wildcard identifier: duplicate
        send_request(make_request(MODE_ADD, 16'h9999, 1'b1, 16'h0005, 1'b0, 16'h0006, 1'b0,
                                  ACT_DENY));
        // differs only in action: a new rule
        send_request(make_request(MODE_ADD, 16'h4321, 1'b1, 16'h0005, 1'b0, 16'h0006, 1'b0,
                                  ACT_ACCEPT));
        send_request(make_request(MODE_CHECK, 16'hABCD, 1'b0, 16'h0005, 1'b0, 16'h0006, 1'b0,
                                  ACT_ACCEPT));
        send_request(make_request(MODE_ADD, 16'h0007, 1'b0, 16'hBEEF, 1'b1, 16'h0008, 1'b0,
                                  ACT_LOG));
        send_request(make_request(MODE_ADD, 16'h0009, 1'b0, 16'h000A, 1'b0, 16'hFFFF, 1'b1,
                                  ACT_ACCEPT));
        send_request(make_request(MODE_ADD, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 16'h8000, 1'b0,
                                  ACT_LOG));
        send_request(make_request(MODE_CHECK, 16'h0007, 1'b0, ID_W'($urandom), 1'b1,
                                  16'h0008, 1'b1, ACT_BAD));
        send_request(make_request(MODE_CHECK, 16'h0009, 1'b0, 16'h000A, 1'b0,
                                  ID_W'($urandom), 1'b0, ACT_DENY));
        send_request(make_request(MODE_CHECK, ID_W'($urandom), 1'b0, ID_W'($urandom), 1'b0,
                                  16'h8000, 1'b0, ACT_ACCEPT));
        send_request(make_request(MODE_CHECK, 16'hAAAA, 1'b1, 16'h5555, 1'b1, 16'h0001, 1'b1,
                                  ACT_LOG));
        drain_results();
    endtask

    task automatic test_random_traffic(input int n, input int idle_pct, input int stall,
                                       input int add_pct);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        repeat (n)
            send_request(random_request(add_pct));
        drain_results();
    endtask

    // fill every slot but the last
    task automatic test_fill_table();
        while (acl_count < TABLE_DEPTH - 1)
            send_request(random_request(100));
    endtask

    task automatic test_full_table();
        // catch-all rule lands in the last slot
        send_request(make_request(MODE_ADD, 16'h1357, 1'b1, 16'h2468, 1'b1, 16'hFFFF, 1'b1,
                                  ACT_BAD));
        // duplicate on a full table, other wildcard identifiers
        send_request(make_request(MODE_ADD, 16'h0000, 1'b1, 16'hFFFF, 1'b1, 16'h0042, 1'b1,
                                  ACT_DENY));
        // new rule with no room
        send_request(make_request(MODE_ADD, 16'h7E57, 1'b0, 16'h7E57, 1'b0, 16'h7E57, 1'b0,
                                  ACT_LOG));
        send_request(make_request(MODE_ADD, acl_rules[0].cli_id, acl_rules[0].client_wild,
                                  acl_rules[0].svc_id, acl_rules[0].service_wild,
                                  acl_rules[0].mth_id, acl_rules[0].method_wild,
                                  acl_rules[0].action));
        send_request(make_request(MODE_CHECK, 16'h7E57, 1'b0, 16'h7E58, 1'b0, 16'h7E59, 1'b0,
                                  ACT_ACCEPT));
        drain_results();
    endtask

    // test sequence
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_deny();
        test_exact_and_duplicate();
        test_wildcard_rules();
        test_random_traffic(250, 0, 0, 30);
        test_random_traffic(250, 56, 0, 30);
        test_fill_table();
        test_full_table();
        test_random_traffic(250, 0, 56, 15);
        test_random_traffic(250, 18, 18, 15);
        test_random_traffic(200, 0, 0, 15);

        send_idle_pct = 0;
        stall_pct     = 0;
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d requests: %0d rules stored, %0d duplicate adds, %0d adds on a full table",
                 request_count, n_added, n_dup, n_full);
        $display("%0d checks matched a rule (deepest index %0d), %0d fell to default deny",
                 n_hit, deepest_hit, n_default);
        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
